// ===== rtl/core/pfe_pkg.sv =====
package pfe_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DIV_CNT_W   = $clog2(DATA_W + 1);

    localparam logic [1:0] MODE_NUMBER   = 2'd0;
    localparam logic [1:0] MODE_OPERATOR = 2'd1;
    localparam logic [1:0] MODE_END      = 2'd2;
    localparam logic [1:0] MODE_INVALID  = 2'd3;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [2:0] ST_ACCEPTED     = 3'd0;
    localparam logic [2:0] ST_FINAL        = 3'd1;
    localparam logic [2:0] ST_DIV_ZERO     = 3'd2;
    localparam logic [2:0] ST_FEW_OPERANDS = 3'd3;
    localparam logic [2:0] ST_BAD_TOKEN    = 3'd4;
    localparam logic [2:0] ST_BAD_EXPR     = 3'd5;
    localparam logic [2:0] ST_OVERFLOW     = 3'd6;
    localparam logic [2:0] ST_SKIPPED      = 3'd7;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [DATA_W-1:0] number_value;
        logic [1:0]               operator_code;
    } in_t;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] final_value;
    } out_t;

endpackage

// ===== rtl/core/pfe_div.sv =====
module pfe_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [pfe_pkg::DATA_W-1:0] dividend,
    input  logic [pfe_pkg::DATA_W-1:0] divisor,
    output logic                       done,
    output logic [pfe_pkg::DATA_W-1:0] quotient
);
    import pfe_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;
    logic                 neg_reg;
    logic [DATA_W-1:0]    mag_b_reg;
    logic [DATA_W-1:0]    rem_reg;
    logic [DATA_W-1:0]    quo_reg;
    logic [DATA_W:0]      trial;
    logic [DATA_W:0]      diff;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DATA_W-1]};
    assign diff  = trial - {1'b0, mag_b_reg};
    assign fits  = trial >= {1'b0, mag_b_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= DIV_CNT_W'(DATA_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg   <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
            mag_b_reg <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
            quo_reg   <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
            rem_reg   <= '0;
        end else if (cnt_reg != '0) begin
            rem_reg <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

endmodule

// ===== rtl/core/postfix_integer_evaluator_top.sv =====
// Evaluates a reverse Polish integer expression, one token per transfer, and returns
// exactly one result transfer per token. Operands live in a 16-entry stack memory with a
// registered read port; a number token is written straight to the stack, while add,
// subtract and multiply take two stack reads, an execute step and a write back, and
// divide runs the 32-step bit-serial divider between execute and write back. An error
// skips tokens until the end mark, and the end mark always empties the stack and clears
// the error. Results wait in an output register until the downstream side takes them.
module postfix_integer_evaluator_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  pfe_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output pfe_pkg::out_t m_data
);
    import pfe_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD_B = 3'd1;
    localparam logic [2:0] S_RD_A = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_WB   = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              aborted_reg, aborted_next;
    logic [1:0]        op_reg, op_next;
    logic [DATA_W-1:0] a_reg, a_next;
    logic [DATA_W-1:0] b_reg, b_next;
    logic [DATA_W-1:0] r_reg, r_next;
    logic [2:0]        res_status_reg, res_status_next;
    logic [DATA_W-1:0] res_value_reg, res_value_next;
    logic              m_valid_reg;
    out_t              m_data_reg;

    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_quotient;
    logic [CNT_W-1:0]  count_m1;
    logic [CNT_W-1:0]  count_m2;
    logic              accept;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign count_m1 = count_reg - CNT_W'(1);
    assign count_m2 = count_reg - CNT_W'(2);

    pfe_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (a_reg),
        .divisor  (b_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        aborted_next    = aborted_reg;
        op_next         = op_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        r_next          = r_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[ADDR_W-1:0];
        mem_wdata       = s_data.number_value;
        mem_re          = 1'b0;
        mem_raddr       = count_m1[ADDR_W-1:0];
        div_start       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next         = s_data.operator_code;
                    res_status_next = ST_ACCEPTED;
                    res_value_next  = '0;
                    state_next      = S_EMIT;
                    if (s_data.mode == MODE_END) begin
                        count_next   = '0;
                        aborted_next = 1'b0;
                        if (aborted_reg) begin
                            res_status_next = ST_SKIPPED;
                        end else if (count_reg == CNT_W'(1)) begin
                            mem_re     = 1'b1;
                            mem_raddr  = '0;
                            state_next = S_FIN;
                        end else begin
                            res_status_next = ST_BAD_EXPR;
                        end
                    end else if (aborted_reg) begin
                        res_status_next = ST_SKIPPED;
                    end else if (s_data.mode == MODE_NUMBER) begin
                        if (count_reg >= CNT_W'(STACK_DEPTH)) begin
                            res_status_next = ST_OVERFLOW;
                            aborted_next    = 1'b1;
                        end else begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end else if (s_data.mode == MODE_OPERATOR) begin
                        if (count_reg < CNT_W'(2)) begin
                            res_status_next = ST_FEW_OPERANDS;
                            aborted_next    = 1'b1;
                        end else begin
                            mem_re     = 1'b1;
                            state_next = S_RD_B;
                        end
                    end else begin
                        res_status_next = ST_BAD_TOKEN;
                        aborted_next    = 1'b1;
                    end
                end
            end
            S_RD_B: begin
                b_next     = rd_data_reg;
                mem_re     = 1'b1;
                mem_raddr  = count_m2[ADDR_W-1:0];
                state_next = S_RD_A;
            end
            S_RD_A: begin
                a_next     = rd_data_reg;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                state_next = S_WB;
                case (op_reg)
                    OP_ADD: r_next = a_reg + b_reg;
                    OP_SUB: r_next = a_reg - b_reg;
                    OP_MUL: r_next = a_reg * b_reg;
                    default: begin
                        if (b_reg == '0) begin
                            res_status_next = ST_DIV_ZERO;
                            aborted_next    = 1'b1;
                            count_next      = count_m2;
                            state_next      = S_EMIT;
                        end else begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    r_next     = div_quotient;
                    state_next = S_WB;
                end
            end
            S_WB: begin
                mem_we     = 1'b1;
                mem_waddr  = count_m2[ADDR_W-1:0];
                mem_wdata  = r_reg;
                count_next = count_m1;
                state_next = S_EMIT;
            end
            S_FIN: begin
                res_status_next = ST_FINAL;
                res_value_next  = rd_data_reg;
                state_next      = S_EMIT;
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= stack_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            aborted_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            aborted_reg <= aborted_next;
            if (state_reg == S_EMIT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        r_reg          <= r_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        if (state_reg == S_EMIT && (!m_valid_reg || m_ready)) begin
            m_data_reg.status      <= res_status_reg;
            m_data_reg.final_value <= res_value_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/core/pfe_checker.sv =====
module pfe_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input pfe_pkg::in_t  s_data,
    input logic          m_valid,
    input logic          m_ready,
    input pfe_pkg::out_t m_data
);
    import pfe_pkg::*;

    // A stalled result transfer holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Only a final value carries a nonzero value.
    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != ST_FINAL) |-> m_data.final_value == '0)
        else $error("nonzero value on a non-final status");

    // Tokens are evaluated one at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("token taken while another is in progress");

    // A token transfer never leaves a result in the next cycle.
    a_no_same_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !($rose(m_valid)))
        else $error("result appeared one cycle after a token");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind postfix_integer_evaluator_top pfe_checker u_pfe_checker (.*);

// ===== bench/postfix_integer_evaluator_top_tb.sv =====
`timescale 1ns / 100ps

module postfix_integer_evaluator_top_tb;
    import pfe_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 60;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    postfix_integer_evaluator_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the operand stack used to predict every result.
    logic [DATA_W-1:0] calc_stack [STACK_DEPTH];
    int   calc_depth  = 0;
    bit   calc_halted = 1'b0;

    out_t pending_results [$];
    int   tokens_evaluated = 0;
    int   mismatches       = 0;
    int   status_seen [8];

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   hold_request  = 1'b0;
    int   hold_left     = 0;

    function automatic logic [DATA_W-1:0] trunc_divide(logic [DATA_W-1:0] num,
                                                       logic [DATA_W-1:0] den);
        logic [DATA_W-1:0] mag_num, mag_den, quo;
        mag_num = num[DATA_W-1] ? '0 - num : num;
        mag_den = den[DATA_W-1] ? '0 - den : den;
        quo     = mag_num / mag_den;
        return (num[DATA_W-1] != den[DATA_W-1]) ? '0 - quo : quo;
    endfunction

    function automatic out_t evaluate_token(in_t tok);
        logic [DATA_W-1:0] lhs, rhs, res;
        out_t outcome;
        outcome.status      = ST_ACCEPTED;
        outcome.final_value = '0;
        res = '0;
        if (tok.mode == MODE_END) begin
            if (calc_halted) begin
                outcome.status = ST_SKIPPED;
            end else if (calc_depth == 1) begin
                outcome.status      = ST_FINAL;
                outcome.final_value = calc_stack[0];
            end else begin
                outcome.status = ST_BAD_EXPR;
            end
            calc_depth  = 0;
            calc_halted = 1'b0;
        end else if (calc_halted) begin
            outcome.status = ST_SKIPPED;
        end else if (tok.mode == MODE_NUMBER) begin
            if (calc_depth >= STACK_DEPTH) begin
                outcome.status = ST_OVERFLOW;
                calc_halted    = 1'b1;
            end else begin
                calc_stack[calc_depth] = tok.number_value;
                calc_depth++;
            end
        end else if (tok.mode == MODE_OPERATOR) begin
            if (calc_depth < 2) begin
                outcome.status = ST_FEW_OPERANDS;
                calc_halted    = 1'b1;
            end else begin
                rhs = calc_stack[calc_depth-1];
                lhs = calc_stack[calc_depth-2];
                calc_depth -= 2;
                case (tok.operator_code)
                    OP_ADD: res = lhs + rhs;
                    OP_SUB: res = lhs - rhs;
                    OP_MUL: res = lhs * rhs;
                    default: begin
                        if (rhs == '0) begin
                            outcome.status = ST_DIV_ZERO;
                            calc_halted    = 1'b1;
                        end else begin
                            res = trunc_divide(lhs, rhs);
                        end
                    end
                endcase
                if (!calc_halted) begin
                    calc_stack[calc_depth] = res;
                    calc_depth++;
                end
            end
        end else begin
            outcome.status = ST_BAD_TOKEN;
            calc_halted    = 1'b1;
        end
        return outcome;
    endfunction

    always @(posedge aclk) begin : token_monitor
        out_t predicted;
        if (aresetn && s_valid && s_ready) begin
            predicted = evaluate_token(s_data);
            pending_results.push_back(predicted);
            tokens_evaluated++;
        end
    end

    always @(posedge aclk) begin : result_checker
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no token outstanding: status %0d value %0d",
                       m_data.status, m_data.final_value);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                status_seen[want.status]++;
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_data.status);
                    mismatches++;
                end
                if (m_data.final_value !== want.final_value) begin
                    $error("final_value: expected %0d, actual %0d",
                           want.final_value, m_data.final_value);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Timed out after %0d cycles.", CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic in_t make_token(logic [1:0] token_kind, logic [DATA_W-1:0] value,
                                       logic [1:0] opcode);
        in_t tok;
        tok.mode          = token_kind;
        tok.number_value  = value;
        tok.operator_code = opcode;
        return tok;
    endfunction

    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            5, 6:    return $urandom_range(200) - 100;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_token(in_t tok);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            s_data  <= make_token(2'($urandom), $urandom, 2'($urandom));
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= tok;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic push_number(logic [DATA_W-1:0] value);
        send_token(make_token(MODE_NUMBER, value, 2'($urandom)));
    endtask

    task automatic apply_operator(logic [1:0] opcode);
        send_token(make_token(MODE_OPERATOR, $urandom, opcode));
    endtask

    task automatic end_expression();
        send_token(make_token(MODE_END, $urandom, 2'($urandom)));
    endtask

    task automatic send_invalid();
        send_token(make_token(MODE_INVALID, $urandom, 2'($urandom)));
    endtask

    task automatic test_operator_extremes();
        push_number(32'h7FFF_FFFF);
        push_number(32'h8000_0000);
        apply_operator(OP_SUB);
        push_number(32'h8000_0000);
        push_number(32'hFFFF_FFFF);
        apply_operator(OP_DIV);
        apply_operator(OP_MUL);
        push_number(32'd1);
        apply_operator(OP_ADD);
        push_number(32'd2);
        apply_operator(OP_DIV);
        end_expression();
    endtask

    task automatic test_division_by_zero();
        push_number(32'd5);
        push_number(32'd0);
        apply_operator(OP_DIV);
        push_number(32'd1);
        send_invalid();
        end_expression();
    endtask

    task automatic test_too_few_operands();
        push_number(32'd1);
        apply_operator(OP_MUL);
        end_expression();
    endtask

    task automatic test_invalid_token();
        send_invalid();
        end_expression();
    endtask

    task automatic test_malformed_end();
        end_expression();
        push_number(32'd1);
        push_number(32'd2);
        end_expression();
    endtask

    // The receiver stalls at the start of this test, so the block has to hold
    // back its input until the stall ends; the stack is then filled past its depth.
    task automatic test_overflow_under_backpressure();
        hold_request = 1'b1;
        repeat (STACK_DEPTH) push_number(pick_operand());
        push_number(pick_operand());
        push_number(pick_operand());
        end_expression();
    endtask

    task automatic inject_fault(int fault_kind);
        case (fault_kind)
            1:       send_invalid();
            2:       push_number(pick_operand());
            3:       apply_operator(2'($urandom));
            4:       end_expression();
            default: repeat (STACK_DEPTH + 1) push_number(pick_operand());
        endcase
    endtask

    task automatic send_expression(int fault_kind);
        int pushes_left, max_depth, depth, step, fault_at;
        bit injected;
        pushes_left = ($urandom_range(7) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 6);
        max_depth   = (pushes_left > 11) ? STACK_DEPTH : $urandom_range(2, 5);
        depth       = 0;
        step        = 0;
        fault_at    = $urandom_range(8);
        injected    = 1'b0;
        while (pushes_left > 0 || depth > 1) begin
            if (fault_kind != 0 && !injected && step == fault_at) begin
                inject_fault(fault_kind);
                injected = 1'b1;
            end
            if (depth >= 2 && (pushes_left == 0 || depth >= max_depth
                               || $urandom_range(2) == 0)) begin
                apply_operator(2'($urandom));
                depth--;
            end else begin
                push_number(pick_operand());
                pushes_left--;
                depth++;
            end
            step++;
        end
        if (fault_kind != 0 && !injected) begin
            inject_fault(fault_kind);
        end
        end_expression();
    endtask

    task automatic test_random_expressions(int sender_pct, int receiver_pct, int token_goal);
        int goal, pick;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        goal = tokens_evaluated + token_goal;
        while (tokens_evaluated < goal) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                send_expression(0);
            end else if (pick < 95) begin
                send_expression($urandom_range(1, 5));
            end else begin
                repeat ($urandom_range(1, 5)) begin
                    send_token(make_token(2'($urandom), $urandom, 2'($urandom)));
                end
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 27;
        recv_idle_pct = 45;
        test_operator_extremes();
        test_division_by_zero();
        test_too_few_operands();
        test_invalid_token();
        test_malformed_end();
        test_overflow_under_backpressure();

        test_random_expressions(27, 45, 300);
        test_random_expressions(45, 27, 300);
        test_random_expressions(0, 0, 300);

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Evaluated %0d tokens under three idle profiles and one long output stall.",
                 tokens_evaluated);
        $display("Seen: %0d final, %0d div0, %0d few, %0d badtok, %0d badexpr, %0d ovf, %0d skip.",
                 status_seen[ST_FINAL], status_seen[ST_DIV_ZERO], status_seen[ST_FEW_OPERANDS],
                 status_seen[ST_BAD_TOKEN], status_seen[ST_BAD_EXPR], status_seen[ST_OVERFLOW],
                 status_seen[ST_SKIPPED]);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/pfe_pkg.sv
rtl/core/pfe_div.sv
rtl/core/postfix_integer_evaluator_top.sv
rtl/core/pfe_checker.sv
bench/postfix_integer_evaluator_top_tb.sv
